[src/assert_macros.svh]
// Assertion macros shared by the HTML entity decoder RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a whole property, disabled while reset is high.
`define HED_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check of an implication, disabled while reset is high.
`define HED_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

[src/hed_pkg.sv]
// Package for the HTML entity decoder: character codes, entity tables,
// queue descriptor and status types. Depends on nothing.
`timescale 1ns / 1ps

package hed_pkg;

   // Character codes used by the matcher and the output sequencer.
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_G  = 8'h67;
   localparam logic [7:0] CHAR_LC_L  = 8'h6C;
   localparam logic [7:0] CHAR_LC_M  = 8'h6D;
   localparam logic [7:0] CHAR_LC_O  = 8'h6F;
   localparam logic [7:0] CHAR_LC_P  = 8'h70;
   localparam logic [7:0] CHAR_LC_Q  = 8'h71;
   localparam logic [7:0] CHAR_LC_T  = 8'h74;
   localparam logic [7:0] CHAR_LC_U  = 8'h75;

   // Results returned per input before the rest carries to the next input.
   localparam int HED_MAX_RUN = 5;

   // Default depth of the queue between the matcher and the sequencer.
   localparam int HED_QUEUE_DEPTH = 4;

   // The four recognized entities.
   typedef enum logic [1:0] {
      ENT_QUOT,
      ENT_LT,
      ENT_GT,
      ENT_AMP
   } ent_type;

   // Work for the output sequencer produced by one input byte. The results
   // are, in order: an optional '&' followed by held_n literal entity bytes,
   // an optional single byte, and an optional lone trailing '&'.
   typedef struct packed {
      logic       seg1;
      logic [2:0] held_n;
      ent_type    ent_id;
      logic       seg2;
      logic [7:0] seg2_byte;
      logic       seg3;
      logic       str_end;
      logic [2:0] total;
   } desc_type;

   // Write side of the queue.
   typedef struct packed {
      logic     valid;
      desc_type desc;
   } q_push_type;

   // Queue occupancy flags.
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Sequencer status, visible for checks.
   typedef struct packed {
      logic       carry;
      logic [2:0] idx;
   } bk_stat_type;

   // Byte at position pos of the entity text after the '&'.
   function automatic logic [7:0] hed_body(ent_type id, logic [2:0] pos);
      logic [7:0] c;
      c = CHAR_SEMI;
      unique case (id)
         ENT_QUOT: begin
            case (pos)
               3'd0: c = CHAR_LC_Q;
               3'd1: c = CHAR_LC_U;
               3'd2: c = CHAR_LC_O;
               3'd3: c = CHAR_LC_T;
               default: c = CHAR_SEMI;
            endcase
         end
         ENT_LT: begin
            case (pos)
               3'd0: c = CHAR_LC_L;
               3'd1: c = CHAR_LC_T;
               default: c = CHAR_SEMI;
            endcase
         end
         ENT_GT: begin
            case (pos)
               3'd0: c = CHAR_LC_G;
               3'd1: c = CHAR_LC_T;
               default: c = CHAR_SEMI;
            endcase
         end
         ENT_AMP: begin
            case (pos)
               3'd0: c = CHAR_LC_A;
               3'd1: c = CHAR_LC_M;
               3'd2: c = CHAR_LC_P;
               default: c = CHAR_SEMI;
            endcase
         end
         default: c = CHAR_SEMI;
      endcase
      return c;
   endfunction

   // Length of the entity text after the '&', including the semicolon.
   function automatic logic [2:0] hed_len(ent_type id);
      logic [2:0] n;
      unique case (id)
         ENT_QUOT: n = 3'd5;
         ENT_LT:   n = 3'd3;
         ENT_GT:   n = 3'd3;
         ENT_AMP:  n = 3'd4;
         default:  n = 3'd5;
      endcase
      return n;
   endfunction

   // Decoded character of an entity.
   function automatic logic [7:0] hed_dec(ent_type id);
      logic [7:0] c;
      unique case (id)
         ENT_QUOT: c = CHAR_QUOTE;
         ENT_LT:   c = CHAR_LT;
         ENT_GT:   c = CHAR_GT;
         ENT_AMP:  c = CHAR_AMP;
         default:  c = CHAR_QUOTE;
      endcase
      return c;
   endfunction

endpackage

[src/hed_req_if.sv]
// Input channel of the HTML entity decoder: one text byte per transfer.
// Stand-alone interface; no package dependency.
`timescale 1ns / 1ps

interface hed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       string_end;

   modport source (output valid, output in_byte, output string_end, input ready);
   modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

[src/hed_rsp_if.sv]
// Result channel of the HTML entity decoder: one output byte per transfer.
// Stand-alone interface; no package dependency.
`timescale 1ns / 1ps

interface hed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       out_string_end;

   modport source (output valid, output out_byte, output run_last,
                   output out_string_end, input ready);
   modport sink   (input valid, input out_byte, input run_last,
                   input out_string_end, output ready);
endinterface

[src/hed_front.sv]
// Front end of the HTML entity decoder: accepts bytes, tracks the partial
// entity match and writes one work descriptor per byte. Uses hed_pkg.
`timescale 1ns / 1ps

module hed_front
   import hed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hed_req_if.sink    req_ch,
   input  logic       q_full,
   output q_push_type q_push
);

   logic       pending_ff, pending_in;
   logic [2:0] held_n_ff, held_n_in;
   ent_type    ent_id_ff, ent_id_in;

   logic       accept;
   logic [7:0] b;
   logic       e;
   ent_type    first_id;
   ent_type    cand_id;
   logic       hit;
   logic       full;
   desc_type   d;
   logic [2:0] lit_len;

   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && !q_full;
   assign b = req_ch.in_byte;
   assign e = req_ch.string_end;

   // Entity selected by the first byte after an '&'.
   always_comb begin
      case (b)
         CHAR_LC_L: first_id = ENT_LT;
         CHAR_LC_G: first_id = ENT_GT;
         CHAR_LC_A: first_id = ENT_AMP;
         default:   first_id = ENT_QUOT;
      endcase
   end

   // The held prefix fixes the entity; the first held byte picks it.
   assign cand_id = (held_n_ff == 3'd0) ? first_id : ent_id_ff;
   assign hit = (b == hed_body(cand_id, held_n_ff));
   assign full = ({1'b0, held_n_ff} + 4'd1) == {1'b0, hed_len(cand_id)};

   // Classify the byte and build the descriptor for the sequencer.
   always_comb begin
      pending_in = pending_ff;
      held_n_in  = held_n_ff;
      ent_id_in  = ent_id_ff;
      d.seg1      = 1'b0;
      d.held_n    = held_n_ff;
      d.ent_id    = ent_id_ff;
      d.seg2      = 1'b0;
      d.seg2_byte = b;
      d.seg3      = 1'b0;
      d.str_end   = e;
      if (!pending_ff) begin
         if (b == CHAR_AMP) begin
            pending_in = !e;
            held_n_in  = 3'd0;
            d.seg3     = e;
         end else begin
            d.seg2 = 1'b1;
         end
      end else if (hit) begin
         if (full) begin
            d.seg2      = 1'b1;
            d.seg2_byte = hed_dec(cand_id);
            pending_in  = 1'b0;
            held_n_in   = 3'd0;
         end else if (e) begin
            // The string ends inside a match: flush it literally.
            d.seg1     = 1'b1;
            d.held_n   = held_n_ff + 3'd1;
            d.ent_id   = cand_id;
            pending_in = 1'b0;
            held_n_in  = 3'd0;
         end else begin
            held_n_in = held_n_ff + 3'd1;
            ent_id_in = cand_id;
         end
      end else begin
         // Mismatch: flush the held text, then take the byte afresh ('&' opens a new match).
         d.seg1    = 1'b1;
         held_n_in = 3'd0;
         if (b == CHAR_AMP) begin
            pending_in = !e;
            d.seg3     = e;
         end else begin
            d.seg2     = 1'b1;
            pending_in = 1'b0;
         end
      end
      lit_len = d.seg1 ? (d.held_n + 3'd1) : 3'd0;
      d.total = lit_len + {2'b00, d.seg2} + {2'b00, d.seg3};
   end

   assign q_push.valid = accept;
   assign q_push.desc  = d;

   // Match state advances on each accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         held_n_ff  <= 3'd0;
      end else if (accept) begin
         pending_ff <= pending_in;
         held_n_ff  <= held_n_in;
      end
      if (accept) begin
         ent_id_ff <= ent_id_in;
      end
   end

endmodule

[src/hed_queue.sv]
// Descriptor queue between the front end and the output sequencer of the
// HTML entity decoder. Uses hed_pkg for the descriptor and status types.
`timescale 1ns / 1ps

module hed_queue
   import hed_pkg::*;
#(
   parameter int DEPTH = HED_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  q_push_type q_push,
   input  logic       pop,
   output desc_type   head,
   output q_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type             entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   // Pointer wrap and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (q_push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(q_push.valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (q_push.valid) begin
         entries_ff[wr_ptr_ff] <= q_push.desc;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

[src/hed_back.sv]
// Output sequencer of the HTML entity decoder: expands queued descriptors
// into result bytes, one per cycle while the output register is free. Uses hed_pkg.
`timescale 1ns / 1ps

module hed_back
   import hed_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  desc_type    head,
   input  q_stat_type  q_stat,
   output logic        pop,
   output bk_stat_type bk_stat,
   hed_rsp_if.source   rsp_ch
);

   localparam logic [2:0] RUN_END  = 3'(HED_MAX_RUN - 1);
   localparam logic [2:0] RUN_OVER = 3'(HED_MAX_RUN + 1);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       end_ff, end_in;
   logic       carry_ff, carry_in;
   logic [7:0] cbyte_ff, cbyte_in;
   logic       cend_ff, cend_in;
   logic [2:0] idx_ff, idx_in;
   logic       out_free;
   logic       load;

   // Result byte at position i of a descriptor's run.
   function automatic logic [7:0] sel_byte(desc_type dd, logic [2:0] i);
      logic [2:0] l1;
      logic [7:0] c;
      l1 = dd.seg1 ? (dd.held_n + 3'd1) : 3'd0;
      if (i < l1) begin
         c = (i == 3'd0) ? CHAR_AMP : hed_body(dd.ent_id, i - 3'd1);
      end else if (dd.seg2 && (i == l1)) begin
         c = dd.seg2_byte;
      end else begin
         c = CHAR_AMP;
      end
      return c;
   endfunction

   assign out_free = !valid_ff || rsp_ch.ready;

   // Sequencing: a carried sixth result goes out ahead of the next run.
   always_comb begin
      pop      = 1'b0;
      load     = 1'b0;
      byte_in  = byte_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      carry_in = carry_ff;
      cbyte_in = cbyte_ff;
      cend_in  = cend_ff;
      idx_in   = idx_ff;
      if (!q_stat.empty) begin
         if (carry_ff) begin
            if (out_free) begin
               load     = 1'b1;
               byte_in  = cbyte_ff;
               last_in  = (head.total == 3'd0);
               end_in   = cend_ff;
               carry_in = 1'b0;
               pop      = (head.total == 3'd0);
            end
         end else if (head.total == 3'd0) begin
            pop = 1'b1;
         end else if (out_free) begin
            load    = 1'b1;
            byte_in = sel_byte(head, idx_ff);
            if ((head.total == RUN_OVER) && (idx_ff == RUN_END)) begin
               last_in  = 1'b1;
               end_in   = 1'b0;
               carry_in = 1'b1;
               cbyte_in = sel_byte(head, RUN_OVER - 3'd1);
               cend_in  = head.str_end;
               pop      = 1'b1;
               idx_in   = 3'd0;
            end else if (idx_ff == (head.total - 3'd1)) begin
               last_in = 1'b1;
               end_in  = head.str_end;
               pop     = 1'b1;
               idx_in  = 3'd0;
            end else begin
               last_in = 1'b0;
               end_in  = 1'b0;
               idx_in  = idx_ff + 3'd1;
            end
         end
      end
      valid_in = load ? 1'b1 : (valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         carry_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         carry_ff <= carry_in;
         idx_ff   <= idx_in;
      end
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      end_ff   <= end_in;
      cbyte_ff <= cbyte_in;
      cend_ff  <= cend_in;
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.out_byte       = byte_ff;
   assign rsp_ch.run_last       = last_ff;
   assign rsp_ch.out_string_end = end_ff;
   assign bk_stat.carry         = carry_ff;
   assign bk_stat.idx           = idx_ff;

endmodule

[src/html_entity_decoder.sv]
// Top level of the HTML entity decoder: front end, descriptor queue and
// output sequencer. Uses hed_pkg, both channel interfaces and assert_macros.svh.
//
// Usage: text bytes arrive on req_ch (valid/ready, in_byte, string_end) and
// decoded bytes leave on rsp_ch (valid/ready, out_byte, run_last,
// out_string_end). The entities &quot; &lt; &gt; &amp; become one byte each;
// a broken match comes out literally, and a match still open at string end
// is flushed literally.
// Throughput: one input byte per cycle while each byte yields at most one
// result and rsp_ch.ready stays high. The output register issues one result
// per cycle while it is free; a byte that releases several results holds the
// sequencer until its last result is issued, and the queue of QUEUE_DEPTH
// descriptors absorbs such bursts before req_ch.ready drops. A result passes
// from the queue entry into the output register. A byte releases at most
// five results; a sixth (only after a broken "&quot" prefix) waits and
// leads the results of the next accepted byte.
// Reset: synchronous, clears the match state, queue and output register.
// When rsp_ch.ready is low the current result holds, the queue fills, and
// then req_ch.ready falls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module html_entity_decoder
   import hed_pkg::*;
#(
   parameter int QUEUE_DEPTH = HED_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   hed_req_if.sink   req_ch,
   hed_rsp_if.source rsp_ch
);

   q_push_type  q_push;
   q_stat_type  q_stat;
   desc_type    head;
   logic        pop;
   bk_stat_type bk_stat;

   // Matching and classification of incoming bytes.
   hed_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_stat.full),
      .q_push (q_push)
   );

   // Decoupling queue.
   hed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (pop),
      .head   (head),
      .q_stat (q_stat)
   );

   // Result sequencing and output register.
   hed_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .q_stat  (q_stat),
      .pop     (pop),
      .bk_stat (bk_stat),
      .rsp_ch  (rsp_ch)
   );

   // A run never advances past its fifth result before ending or carrying.
   `HED_ASSERT(a_idx_range, clock, reset, bk_stat.idx <= 3'(HED_MAX_RUN - 1),
      "run index overflow")

   // A carried result is set only together with the fifth result marked last.
   `HED_ASSERT_IMPL(a_carry_last, clock, reset, $rose(bk_stat.carry),
      rsp_ch.valid && rsp_ch.run_last, "carry without run end")

   // A new result appears only when the queue held work.
   `HED_ASSERT_IMPL(a_valid_src, clock, reset, $rose(rsp_ch.valid),
      $past(!q_stat.empty), "result from empty queue")

endmodule
